// File: hdl/sct_pkg.sv
`default_nettype none
// Shared types and widths for the segment crossing test.
// Has no dependencies; every other file of the block imports it.
package sct_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int OFF_WIDTH   = COORD_WIDTH + 2;
    localparam int PROD_WIDTH  = COORD_WIDTH + OFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int DOT_WIDTH   = PROD_WIDTH + 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [OFF_WIDTH-1:0]   off_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;
    typedef logic signed [DOT_WIDTH-1:0]   dot_t;
    typedef logic signed [1:0]             side_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } coord_vec_t;

    typedef struct packed {
        off_t x;
        off_t y;
        off_t z;
    } off_vec_t;

    typedef struct packed {
        logic s2;
        logic s3;
    } stage_en_t;

    localparam side_t SIDE_ZERO = 2'sb00;
    localparam side_t SIDE_POS  = 2'sb01;
    localparam side_t SIDE_NEG  = 2'sb11;

endpackage
`default_nettype wire

// File: hdl/sct_side.sv
`default_nettype none
// Two-stage side unit: signed side of one point offset against one direction.
// Depends on sct_pkg for vector types, widths and side codes.
module sct_side (
    input  wire logic                clk,
    input  wire sct_pkg::stage_en_t  en,
    input  wire sct_pkg::coord_vec_t dir,
    input  wire sct_pkg::off_vec_t   off,
    output sct_pkg::side_t           side
);
    import sct_pkg::*;

    prod_t m_yz_reg, m_zy_reg, m_xz_reg, m_zx_reg, m_xy_reg, m_yx_reg;
    prod_t m_xx_reg, m_yy_reg, m_zz_reg;
    logic  zero_reg;
    logic  zero_next;
    cross_t cx, cy, cz;
    dot_t   dot;
    side_t  side_next;
    side_t  side_reg;

    assign zero_next = ((dir.x == '0) && (dir.y == '0) && (dir.z == '0)) ||
                       ((off.x == '0) && (off.y == '0) && (off.z == '0));

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            m_yz_reg <= prod_t'(dir.y) * prod_t'(off.z);
            m_zy_reg <= prod_t'(dir.z) * prod_t'(off.y);
            m_xz_reg <= prod_t'(dir.x) * prod_t'(off.z);
            m_zx_reg <= prod_t'(dir.z) * prod_t'(off.x);
            m_xy_reg <= prod_t'(dir.x) * prod_t'(off.y);
            m_yx_reg <= prod_t'(dir.y) * prod_t'(off.x);
            m_xx_reg <= prod_t'(dir.x) * prod_t'(off.x);
            m_yy_reg <= prod_t'(dir.y) * prod_t'(off.y);
            m_zz_reg <= prod_t'(dir.z) * prod_t'(off.z);
            zero_reg <= zero_next;
        end
    end

    always_comb
    begin
        cx  = cross_t'(m_yz_reg) - cross_t'(m_zy_reg);
        cy  = cross_t'(m_xz_reg) - cross_t'(m_zx_reg);
        cz  = cross_t'(m_xy_reg) - cross_t'(m_yx_reg);
        dot = dot_t'(m_xx_reg) + dot_t'(m_yy_reg) + dot_t'(m_zz_reg);
        if (zero_reg)
            side_next = SIDE_ZERO;
        else if (cz < 0)
            side_next = SIDE_NEG;
        else if (cz != '0)
            side_next = SIDE_POS;
        else if ((cx != '0) || (cy != '0))
            side_next = SIDE_ZERO;
        else if (dot < 0)
            side_next = SIDE_POS;
        else
            side_next = SIDE_ZERO;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
            side_reg <= side_next;
    end

    assign side = side_reg;

endmodule
`default_nettype wire

// File: hdl/segment_crossing_test_top.sv
`default_nettype none
// Top level of the segment crossing test: offset stage, four side units, output stage.
// Depends on sct_pkg and sct_side.
//
// Each beat carries two segments (start point and direction, 16-bit signed
// components) and yields one result beat with the four exact side signs and
// the crossed flag. The block accepts one beat per clock when nothing stalls;
// the four pipeline stages are the offset subtraction, the nine products per
// side unit, the cross and dot reduction, and the output register.
// Backpressure on the result side holds every stage that has no empty slot
// ahead of it.
module segment_crossing_test_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire sct_pkg::coord_t a_start_x,
    input  wire sct_pkg::coord_t a_start_y,
    input  wire sct_pkg::coord_t a_start_z,
    input  wire sct_pkg::coord_t a_dir_x,
    input  wire sct_pkg::coord_t a_dir_y,
    input  wire sct_pkg::coord_t a_dir_z,
    input  wire sct_pkg::coord_t b_start_x,
    input  wire sct_pkg::coord_t b_start_y,
    input  wire sct_pkg::coord_t b_start_z,
    input  wire sct_pkg::coord_t b_dir_x,
    input  wire sct_pkg::coord_t b_dir_y,
    input  wire sct_pkg::coord_t b_dir_z,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output logic                 crossed,
    output sct_pkg::side_t       side_a_of_b_start,
    output sct_pkg::side_t       side_a_of_b_end,
    output sct_pkg::side_t       side_b_of_a_start,
    output sct_pkg::side_t       side_b_of_a_end
);
    import sct_pkg::*;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic en1, en2, en3, en_out;
    stage_en_t side_en;

    coord_vec_t a_dir_reg, b_dir_reg;
    off_vec_t   p_start_reg, p_end_reg, q_start_reg, q_end_reg;
    off_vec_t   p_start_next, p_end_next, q_start_next, q_end_next;

    side_t s_ab_start, s_ab_end, s_ba_start, s_ba_end;
    side_t s_ab_start_reg, s_ab_end_reg, s_ba_start_reg, s_ba_end_reg;
    logic  crossed_reg, crossed_next;

    assign en_out  = !out_valid_reg || result_ready;
    assign en3     = !s3_valid_reg || en_out;
    assign en2     = !s2_valid_reg || en3;
    assign en1     = !s1_valid_reg || en2;
    assign item_ready = en1;
    assign side_en = '{s2: en2, s3: en3};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= item_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en_out)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_comb
    begin
        p_start_next.x = off_t'(b_start_x) - off_t'(a_start_x);
        p_start_next.y = off_t'(b_start_y) - off_t'(a_start_y);
        p_start_next.z = off_t'(b_start_z) - off_t'(a_start_z);
        p_end_next.x   = off_t'(b_start_x) + off_t'(b_dir_x) - off_t'(a_start_x);
        p_end_next.y   = off_t'(b_start_y) + off_t'(b_dir_y) - off_t'(a_start_y);
        p_end_next.z   = off_t'(b_start_z) + off_t'(b_dir_z) - off_t'(a_start_z);
        q_start_next.x = off_t'(a_start_x) - off_t'(b_start_x);
        q_start_next.y = off_t'(a_start_y) - off_t'(b_start_y);
        q_start_next.z = off_t'(a_start_z) - off_t'(b_start_z);
        q_end_next.x   = off_t'(a_start_x) + off_t'(a_dir_x) - off_t'(b_start_x);
        q_end_next.y   = off_t'(a_start_y) + off_t'(a_dir_y) - off_t'(b_start_y);
        q_end_next.z   = off_t'(a_start_z) + off_t'(a_dir_z) - off_t'(b_start_z);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            a_dir_reg   <= '{x: a_dir_x, y: a_dir_y, z: a_dir_z};
            b_dir_reg   <= '{x: b_dir_x, y: b_dir_y, z: b_dir_z};
            p_start_reg <= p_start_next;
            p_end_reg   <= p_end_next;
            q_start_reg <= q_start_next;
            q_end_reg   <= q_end_next;
        end
    end

    sct_side u_side_ab_start (
        .clk  (clk),
        .en   (side_en),
        .dir  (a_dir_reg),
        .off  (p_start_reg),
        .side (s_ab_start)
    );

    sct_side u_side_ab_end (
        .clk  (clk),
        .en   (side_en),
        .dir  (a_dir_reg),
        .off  (p_end_reg),
        .side (s_ab_end)
    );

    sct_side u_side_ba_start (
        .clk  (clk),
        .en   (side_en),
        .dir  (b_dir_reg),
        .off  (q_start_reg),
        .side (s_ba_start)
    );

    sct_side u_side_ba_end (
        .clk  (clk),
        .en   (side_en),
        .dir  (b_dir_reg),
        .off  (q_end_reg),
        .side (s_ba_end)
    );

    // A pair is strictly opposite when both signs are nonzero and differ.
    assign crossed_next = (s_ab_start != SIDE_ZERO) && (s_ab_end != SIDE_ZERO) &&
                          (s_ab_start[1] != s_ab_end[1]) &&
                          (s_ba_start != SIDE_ZERO) && (s_ba_end != SIDE_ZERO) &&
                          (s_ba_start[1] != s_ba_end[1]);

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            crossed_reg    <= crossed_next;
            s_ab_start_reg <= s_ab_start;
            s_ab_end_reg   <= s_ab_end;
            s_ba_start_reg <= s_ba_start;
            s_ba_end_reg   <= s_ba_end;
        end
    end

    assign result_valid      = out_valid_reg;
    assign crossed           = crossed_reg;
    assign side_a_of_b_start = s_ab_start_reg;
    assign side_a_of_b_end   = s_ab_end_reg;
    assign side_b_of_a_start = s_ba_start_reg;
    assign side_b_of_a_end   = s_ba_end_reg;

endmodule
`default_nettype wire

// File: dv/tb_segment_crossing_test_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for segment_crossing_test_top: directed and random segment pairs.
// Predicts the four side signs and the crossed flag of every beat; depends on sct_pkg.
module tb_segment_crossing_test_top;
    import sct_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_PAIRS = 700;

    typedef struct {
        coord_vec_t a_start;
        coord_vec_t a_dir;
        coord_vec_t b_start;
        coord_vec_t b_dir;
    } segment_pair_t;

    typedef struct {
        logic  crossed;
        side_t a_of_b_start;
        side_t a_of_b_end;
        side_t b_of_a_start;
        side_t b_of_a_end;
    } crossing_t;

    logic   clk;
    logic   rst_n;
    logic   item_valid;
    logic   item_ready;
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_dir_x;
    coord_t a_dir_y;
    coord_t a_dir_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_dir_x;
    coord_t b_dir_y;
    coord_t b_dir_z;
    logic   result_valid;
    logic   result_ready;
    logic   crossed;
    side_t  side_a_of_b_start;
    side_t  side_a_of_b_end;
    side_t  side_b_of_a_start;
    side_t  side_b_of_a_end;

    crossing_t expected_crossings[$];
    crossing_t oldest_crossing;
    int        error_count = 0;
    int        cycle_count = 0;
    bit        steady      = 1'b0;

    segment_crossing_test_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .a_start_x         (a_start_x),
        .a_start_y         (a_start_y),
        .a_start_z         (a_start_z),
        .a_dir_x           (a_dir_x),
        .a_dir_y           (a_dir_y),
        .a_dir_z           (a_dir_z),
        .b_start_x         (b_start_x),
        .b_start_y         (b_start_y),
        .b_start_z         (b_start_z),
        .b_dir_x           (b_dir_x),
        .b_dir_y           (b_dir_y),
        .b_dir_z           (b_dir_z),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .crossed           (crossed),
        .side_a_of_b_start (side_a_of_b_start),
        .side_a_of_b_end   (side_a_of_b_end),
        .side_b_of_a_start (side_b_of_a_start),
        .side_b_of_a_end   (side_b_of_a_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic side_t point_side(input longint dx, input longint dy, input longint dz,
                                         input longint px, input longint py, input longint pz);
        longint cx;
        longint cy;
        longint cz;
        longint dot;
        if ((dx == 0 && dy == 0 && dz == 0) || (px == 0 && py == 0 && pz == 0))
            return SIDE_ZERO;
        cx = dy * pz - dz * py;
        cy = dx * pz - dz * px;
        cz = dx * py - dy * px;
        if (cx != 0 || cy != 0 || cz != 0)
            return (cz > 0) ? SIDE_POS : ((cz < 0) ? SIDE_NEG : SIDE_ZERO);
        dot = dx * px + dy * py + dz * pz;
        return (dot < 0) ? SIDE_POS : SIDE_ZERO;
    endfunction

    function automatic logic strictly_opposite(input side_t s, input side_t t);
        return (s == SIDE_POS && t == SIDE_NEG) || (s == SIDE_NEG && t == SIDE_POS);
    endfunction

    function automatic crossing_t predict_crossing(input segment_pair_t sp);
        longint    ax;
        longint    ay;
        longint    az;
        longint    adx;
        longint    ady;
        longint    adz;
        longint    bx;
        longint    by_;
        longint    bz;
        longint    bdx;
        longint    bdy;
        longint    bdz;
        crossing_t r;
        ax  = sp.a_start.x;
        ay  = sp.a_start.y;
        az  = sp.a_start.z;
        adx = sp.a_dir.x;
        ady = sp.a_dir.y;
        adz = sp.a_dir.z;
        bx  = sp.b_start.x;
        by_ = sp.b_start.y;
        bz  = sp.b_start.z;
        bdx = sp.b_dir.x;
        bdy = sp.b_dir.y;
        bdz = sp.b_dir.z;
        r.a_of_b_start = point_side(adx, ady, adz, bx - ax, by_ - ay, bz - az);
        r.a_of_b_end   = point_side(adx, ady, adz, bx + bdx - ax, by_ + bdy - ay, bz + bdz - az);
        r.b_of_a_start = point_side(bdx, bdy, bdz, ax - bx, ay - by_, az - bz);
        r.b_of_a_end   = point_side(bdx, bdy, bdz, ax + adx - bx, ay + ady - by_, az + adz - bz);
        r.crossed = strictly_opposite(r.a_of_b_start, r.a_of_b_end) &&
                    strictly_opposite(r.b_of_a_start, r.b_of_a_end);
        return r;
    endfunction

    function automatic segment_pair_t pair_of(input int ax, input int ay, input int az,
                                              input int adx, input int ady, input int adz,
                                              input int bx, input int by_, input int bz,
                                              input int bdx, input int bdy, input int bdz);
        segment_pair_t sp;
        sp.a_start.x = coord_t'(ax);
        sp.a_start.y = coord_t'(ay);
        sp.a_start.z = coord_t'(az);
        sp.a_dir.x   = coord_t'(adx);
        sp.a_dir.y   = coord_t'(ady);
        sp.a_dir.z   = coord_t'(adz);
        sp.b_start.x = coord_t'(bx);
        sp.b_start.y = coord_t'(by_);
        sp.b_start.z = coord_t'(bz);
        sp.b_dir.x   = coord_t'(bdx);
        sp.b_dir.y   = coord_t'(bdy);
        sp.b_dir.z   = coord_t'(bdz);
        return sp;
    endfunction

    function automatic int span(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_pair(input segment_pair_t sp);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        a_start_x  <= sp.a_start.x;
        a_start_y  <= sp.a_start.y;
        a_start_z  <= sp.a_start.z;
        a_dir_x    <= sp.a_dir.x;
        a_dir_y    <= sp.a_dir.y;
        a_dir_z    <= sp.a_dir.z;
        b_start_x  <= sp.b_start.x;
        b_start_y  <= sp.b_start.y;
        b_start_z  <= sp.b_start.z;
        b_dir_x    <= sp.b_dir.x;
        b_dir_y    <= sp.b_dir.y;
        b_dir_z    <= sp.b_dir.z;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        expected_crossings.push_back(predict_crossing(sp));
    endtask

    task automatic test_extreme_coordinates();
        send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767,
                          -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(pair_of(-32768, 32767, -32768, 32767, -32768, 32767,
                          32767, -32768, 32767, -32768, 32767, -32768));
        send_pair(pair_of(-32768, 0, 0, 32767, 0, 0, 0, -32768, 0, 0, 32767, 0));
    endtask

    task automatic test_zero_vectors();
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(3, -4, 5, 0, 0, 0, -7, 2, 1, 6, 6, -6));
        send_pair(pair_of(3, -4, 5, 9, 1, -2, -7, 2, 1, 0, 0, 0));
        send_pair(pair_of(10, 20, 30, 5, -5, 1, 10, 20, 30, -3, 8, 2));
    endtask

    task automatic test_parallel_segments();
        send_pair(pair_of(0, 0, 0, 10, 10, 0, 20, 20, 0, 5, 5, 0));
        send_pair(pair_of(0, 0, 0, 10, 10, 0, 20, 20, 0, -30, -30, 0));
        send_pair(pair_of(0, 0, 0, 10, 0, 0, 0, 5, 0, 10, 0, 0));
        send_pair(pair_of(-100, 0, 0, 50, 0, 0, 100, 0, 0, -400, 0, 0));
    endtask

    task automatic test_crossing_segments();
        send_pair(pair_of(-10, 0, 0, 20, 0, 0, 0, -10, 0, 0, 20, 0));
        send_pair(pair_of(-10, 0, 0, 20, 0, 0, 0, 10, 0, 0, -20, 0));
        send_pair(pair_of(0, 0, 0, 10, 0, 0, 5, 0, 0, 0, 7, 0));
        send_pair(pair_of(0, 0, 0, 10, 0, 0, 5, 0, -5, 0, 0, 10));
        send_pair(pair_of(-30000, -30000, 100, 32767, 32767, -200,
                          30000, -30000, -100, -32768, 32767, 200));
        send_pair(pair_of(0, 0, 0, 10, 0, 0, 0, 1, 0, 0, 20, 0));
    endtask

    task automatic test_random_pairs();
        segment_pair_t sp;
        int            kind;
        int            k;
        int            m;
        int            c[3];
        int            ha[3];
        int            hb[3];
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            steady = (n >= 250 && n < 400);
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                sp = pair_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            else if (kind < 70)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    c[i]  = span(16000);
                    ha[i] = span(8000);
                    hb[i] = span(8000);
                end
                sp = pair_of(c[0] - ha[0], c[1] - ha[1], c[2] - ha[2],
                             2 * ha[0], 2 * ha[1], 2 * ha[2],
                             c[0] - hb[0], c[1] - hb[1], c[2] - hb[2],
                             2 * hb[0], 2 * hb[1], 2 * hb[2]);
            end
            else if (kind < 85)
            begin
                k = ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 2))
                                                : -int'($urandom_range(1, 2));
                m = span(2);
                for (int i = 0; i < 3; i++)
                begin
                    c[i]  = span(8000);
                    ha[i] = span(8000);
                    hb[i] = ($urandom_range(0, 2) == 0) ? span(3) : 0;
                end
                sp = pair_of(c[0], c[1], c[2], ha[0], ha[1], ha[2],
                             c[0] + m * ha[0] + hb[0], c[1] + m * ha[1] + hb[1],
                             c[2] + m * ha[2] + hb[2],
                             k * ha[0], k * ha[1], k * ha[2]);
            end
            else
            begin
                sp = pair_of(span(3), span(3), span(3), span(3), span(3), span(3),
                             span(3), span(3), span(3), span(3), span(3), span(3));
            end
            send_pair(sp);
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            result_ready <= steady || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_crossings.size() == 0)
                report_mismatch("result beat with nothing expected", 1, 0);
            else
            begin
                oldest_crossing = expected_crossings.pop_front();
                if (crossed !== oldest_crossing.crossed)
                    report_mismatch("crossed", crossed, oldest_crossing.crossed);
                if (side_a_of_b_start !== oldest_crossing.a_of_b_start)
                    report_mismatch("side_a_of_b_start", side_a_of_b_start,
                                    oldest_crossing.a_of_b_start);
                if (side_a_of_b_end !== oldest_crossing.a_of_b_end)
                    report_mismatch("side_a_of_b_end", side_a_of_b_end,
                                    oldest_crossing.a_of_b_end);
                if (side_b_of_a_start !== oldest_crossing.b_of_a_start)
                    report_mismatch("side_b_of_a_start", side_b_of_a_start,
                                    oldest_crossing.b_of_a_start);
                if (side_b_of_a_end !== oldest_crossing.b_of_a_end)
                    report_mismatch("side_b_of_a_end", side_b_of_a_end,
                                    oldest_crossing.b_of_a_end);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        result_ready = 1'b0;
        a_start_x    = '0;
        a_start_y    = '0;
        a_start_z    = '0;
        a_dir_x      = '0;
        a_dir_y      = '0;
        a_dir_z      = '0;
        b_start_x    = '0;
        b_start_y    = '0;
        b_start_z    = '0;
        b_dir_x      = '0;
        b_dir_y      = '0;
        b_dir_z      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_coordinates();
        test_zero_vectors();
        test_parallel_segments();
        test_crossing_segments();
        test_random_pairs();
        item_valid <= 1'b0;
        while (expected_crossings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/sct_pkg.sv
hdl/sct_side.sv
hdl/segment_crossing_test_top.sv
dv/tb_segment_crossing_test_top.sv
